/* hdl/array_insert_delete_search_macros.svh */
// Assertion macros for the ordered array block.
`ifndef ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH
`define ARRAY_INSERT_DELETE_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled during reset
`define AIDS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled during reset
`define AIDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/aids_pkg.sv */
// Types and constants for the ordered array block.
`timescale 1ns / 1ps

package aids_pkg;

    // Entry store depth; every index and count field is IDX_W bits wide
    localparam int DEPTH  = 16;
    localparam int IDX_W  = 5;
    localparam int DATA_W = 32;
    localparam logic [IDX_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_SEARCH = 2'd2,
        CMD_DUMP   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_RANGE     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_INS_SHIFT,
        S_INS_WRITE,
        S_DEL_SHIFT,
        S_SEARCH,
        S_DUMP
    } state_t;

endpackage

/* hdl/array_insert_delete_search.sv */
// Ordered array of signed words: insert, delete, linear search and dump.
// One command at a time; one RAM read and one write per cycle set the pace.
// Dump streams one entry per cycle when the output is not stalled.
// Reset clears the fill count and sets capacity to 16; RAM contents stay unknown.
`timescale 1ns / 1ps

`include "array_insert_delete_search_macros.svh"

module array_insert_delete_search
    import aids_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration: capacity_limit
    input  logic        cfg_wr_en,
    input  logic [4:0]  cfg_wr_data,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // value[31:0], position[36:32], zero pad
    input  logic [1:0]  s_axis_tuser,   // cmd[1:0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // found_index[4:0], data[36:5],
                                        // fill_count[41:37], zero pad
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Entry store, one write and one registered read per cycle
    logic signed [DATA_W-1:0] mem [DEPTH];

    state_t                   state_reg, state_next;
    cmd_t                     cmd_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [IDX_W-1:0]         pos_reg;
    logic [IDX_W-1:0]         count_reg, count_next;
    logic [IDX_W-1:0]         cap_reg;
    logic [IDX_W-1:0]         ptr_reg, ptr_next;
    logic [IDX_W-1:0]         rem_reg, rem_next;
    logic                     rd_valid_reg, rd_valid_next;
    logic [IDX_W-1:0]         rd_idx_reg;
    logic signed [DATA_W-1:0] rd_data_reg;

    logic                     out_valid_reg;
    status_t                  out_status_reg;
    logic [IDX_W-1:0]         out_idx_reg;
    logic signed [DATA_W-1:0] out_data_reg;
    logic [IDX_W-1:0]         out_count_reg;
    logic                     out_last_reg;

    logic                     rd_en, wr_en;
    logic [IDX_W-1:0]         rd_idx, wr_idx;
    logic signed [DATA_W-1:0] wr_data;
    logic                     out_free, out_load, out_last;
    status_t                  out_status;
    logic [IDX_W-1:0]         out_idx;
    logic signed [DATA_W-1:0] out_data;
    logic [IDX_W-1:0]         eff_cap;
    logic                     hit;

    // Capacity never exceeds the RAM depth
    assign eff_cap  = (32'(cap_reg) < DEPTH) ? cap_reg : IDX_W'(DEPTH);
    assign out_free = !out_valid_reg || m_axis_tready;
    assign hit      = rd_valid_reg && (rd_data_reg == val_reg);

    assign s_axis_tready = (state_reg == S_IDLE);

    // RAM port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(wr_idx)] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[AW'(rd_idx)];
            rd_idx_reg  <= rd_idx;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_load || (out_valid_reg && !m_axis_tready);
            if (cfg_wr_en)
            begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    // Command capture, walk pointers and output register
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg <= cmd_t'(s_axis_tuser);
            val_reg <= s_axis_tdata[31:0];
            pos_reg <= s_axis_tdata[36:32];
        end
        ptr_reg <= ptr_next;
        rem_reg <= rem_next;
        if (out_load)
        begin
            out_status_reg <= out_status;
            out_idx_reg    <= out_idx;
            out_data_reg   <= out_data;
            out_count_reg  <= count_next;
            out_last_reg   <= out_last;
        end
    end

    // Sequencer: next state, RAM accesses and result generation
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        ptr_next      = ptr_reg;
        rem_next      = rem_reg;
        rd_en         = 1'b0;
        rd_idx        = ptr_reg;
        wr_en         = 1'b0;
        wr_idx        = rd_idx_reg;
        wr_data       = rd_data_reg;
        out_load      = 1'b0;
        out_status    = ST_OK;
        out_idx       = '0;
        out_data      = '0;
        out_last      = 1'b1;
        rd_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (count_reg >= eff_cap)
                        begin
                            out_status = ST_FULL;
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else if (pos_reg > count_reg)
                        begin
                            out_status = ST_RANGE;
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ptr_next   = count_reg - 5'd1;
                            rem_next   = count_reg - pos_reg;
                            state_next = S_INS_SHIFT;
                        end
                    end
                    CMD_DELETE:
                    begin
                        if (pos_reg >= count_reg)
                        begin
                            out_status = ST_RANGE;
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ptr_next   = pos_reg + 5'd1;
                            rem_next   = count_reg - pos_reg - 5'd1;
                            state_next = S_DEL_SHIFT;
                        end
                    end
                    CMD_SEARCH:
                    begin
                        ptr_next   = '0;
                        rem_next   = count_reg;
                        state_next = S_SEARCH;
                    end
                    CMD_DUMP:
                    begin
                        if (count_reg == '0)
                        begin
                            out_status = ST_NOT_FOUND;
                            if (out_free)
                            begin
                                out_load   = 1'b1;
                                state_next = S_IDLE;
                            end
                        end
                        else
                        begin
                            ptr_next   = '0;
                            rem_next   = count_reg;
                            state_next = S_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end

            // Move entries up, reading downward from the top
            S_INS_SHIFT:
            begin
                if (rd_valid_reg)
                begin
                    wr_en  = 1'b1;
                    wr_idx = rd_idx_reg + 5'd1;
                end
                if (rem_reg != '0)
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg - 5'd1;
                    rem_next = rem_reg - 5'd1;
                end
                else
                begin
                    state_next = S_INS_WRITE;
                end
                rd_valid_next = rd_en;
            end

            S_INS_WRITE:
            begin
                if (out_free)
                begin
                    wr_en      = 1'b1;
                    wr_idx     = pos_reg;
                    wr_data    = val_reg;
                    count_next = count_reg + 5'd1;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            // Move entries down, reading upward from above the hole
            S_DEL_SHIFT:
            begin
                if (rd_valid_reg)
                begin
                    wr_en  = 1'b1;
                    wr_idx = rd_idx_reg - 5'd1;
                end
                if (rem_reg != '0)
                begin
                    rd_en    = 1'b1;
                    ptr_next = ptr_reg + 5'd1;
                    rem_next = rem_reg - 5'd1;
                end
                else if (out_free)
                begin
                    count_next = count_reg - 5'd1;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
                rd_valid_next = rd_en;
            end

            // Compare one entry per cycle, first match wins
            S_SEARCH:
            begin
                if (hit)
                begin
                    out_idx = rd_idx_reg;
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        rd_valid_next = 1'b1;
                    end
                end
                else if (rem_reg != '0)
                begin
                    rd_en         = 1'b1;
                    ptr_next      = ptr_reg + 5'd1;
                    rem_next      = rem_reg - 5'd1;
                    rd_valid_next = 1'b1;
                end
                else if (!rd_valid_reg)
                begin
                    out_status = ST_NOT_FOUND;
                    if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end

            // Stream entries; read data holds while the output is stalled
            S_DUMP:
            begin
                out_idx  = rd_idx_reg;
                out_data = rd_data_reg;
                out_last = (rd_idx_reg == count_reg - 5'd1);
                if (rd_valid_reg)
                begin
                    if (out_free)
                    begin
                        out_load = 1'b1;
                        if (out_last)
                        begin
                            state_next = S_IDLE;
                        end
                        else if (rem_reg != '0)
                        begin
                            rd_en    = 1'b1;
                            ptr_next = ptr_reg + 5'd1;
                            rem_next = rem_reg - 5'd1;
                        end
                        rd_valid_next = rd_en;
                    end
                    else
                    begin
                        rd_valid_next = 1'b1;
                    end
                end
                else if (rem_reg != '0)
                begin
                    rd_en         = 1'b1;
                    ptr_next      = ptr_reg + 5'd1;
                    rem_next      = rem_reg - 5'd1;
                    rd_valid_next = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Result stream
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_count_reg, out_data_reg, out_idx_reg};

    // Checks
    `AIDS_ASSERT_NOW(a_no_result_overwrite, out_load, out_free,
        "result loaded over one still waiting")
    `AIDS_ASSERT_NEXT(a_count_moves_with_result, !out_load, count_reg == $past(count_reg),
        "fill count changed without a result")
    `AIDS_ASSERT_NEXT(a_insert_grows, (state_reg == S_INS_WRITE) && out_load,
        count_reg == $past(count_reg) + 5'd1, "insert did not grow the fill count")
    `AIDS_ASSERT_NOW(a_no_same_entry_access, wr_en && rd_en, wr_idx != rd_idx,
        "read and write of the same entry in one cycle")

endmodule
